// File: design/plrp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrp_pkg
// Types, codes and constants shared by the packed log record parser.
// ---------------------------------------------------------------------------
package plrp_pkg;

    localparam int MAX_RES     = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] TYPE_FILEHDR = 8'd25;
    localparam logic [7:0] TYPE_COMMIT  = 8'd17;
    localparam logic [7:0] TYPE_USER    = 8'd33;
    localparam logic [7:0] FLAG_VLSN    = 8'h28;   // 0x20 or 0x08
    localparam logic [7:0] PACK_BIAS    = 8'd119;
    localparam logic [7:0] PACK_NEG_LO  = 8'd137;  // -119 as a byte
    localparam logic [63:0] KEY_FLIP    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] OP_NONE     = 64'h0000_0000_0000_FFFF;

    // result field ids
    localparam logic [4:0] FID_CSUM      = 5'd0;
    localparam logic [4:0] FID_TYPE      = 5'd1;
    localparam logic [4:0] FID_FLAGS     = 5'd2;
    localparam logic [4:0] FID_PREV      = 5'd3;
    localparam logic [4:0] FID_SIZE      = 5'd4;
    localparam logic [4:0] FID_VLSN      = 5'd5;
    localparam logic [4:0] FID_FH_FIRST  = 5'd6;
    localparam logic [4:0] FID_CM_FIRST  = 5'd10;
    localparam logic [4:0] FID_CM_MASTER = 5'd13;
    localparam logic [4:0] FID_CM_LAST   = 5'd14;
    localparam logic [4:0] FID_U_FLAG    = 5'd15;
    localparam logic [4:0] FID_U_FLAG2   = 5'd16;
    localparam logic [4:0] FID_U_DBID    = 5'd17;
    localparam logic [4:0] FID_U_ABORT   = 5'd18;
    localparam logic [4:0] FID_U_TXN     = 5'd19;
    localparam logic [4:0] FID_U_DSIZE   = 5'd21;
    localparam logic [4:0] FID_U_OP      = 5'd22;
    localparam logic [4:0] FID_U_KEY     = 5'd23;
    localparam logic [4:0] FID_END       = 5'd24;

    // record end status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_KEYLEN  = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_BADCODE = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_VLSN     = 4'd1,
        PH_FILEHDR  = 4'd2,
        PH_COMMIT   = 4'd3,
        PH_USER     = 4'd4,
        PH_UDATA    = 4'd5,
        PH_KEY      = 4'd6,
        PH_TRAIL    = 4'd7,
        PH_ERR_KEY  = 4'd8,
        PH_ERR_OVER = 4'd9,
        PH_ERR_CODE = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        PK_PEND = 2'd0,
        PK_DONE = 2'd1,
        PK_BAD  = 2'd2
    } t_pk_code;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [63:0] field_value;
        logic [7:0]  rec_type;
        logic [1:0]  status;
        logic        last_of_run;
    } t_result;

    // all results of one byte, in order
    typedef struct packed {
        logic [1:0]            cnt;
        t_result [MAX_RES-1:0] res;
    } t_step_out;

    function automatic logic [1:0] phase_status(input t_phase ph);
        logic [1:0] st;
        unique case (ph)
            PH_TRAIL:    st = ST_OK;
            PH_ERR_KEY:  st = ST_KEYLEN;
            PH_ERR_CODE: st = ST_BADCODE;
            default:     st = ST_OVERRUN;
        endcase
        return st;
    endfunction

endpackage

// File: design/plrp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrp_if
// Valid/ready channels: raw log bytes in, decoded result words out.
// ---------------------------------------------------------------------------
interface plrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface plrp_rec_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [7:0]  rec_type;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (output valid, output field_id, output field_value,
                    output rec_type, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input field_id, input field_value,
                    input rec_type, input status, input last_of_run,
                    output ready);
endinterface

// File: design/packed_log_record_parser_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packed_log_record_parser_unit
// Streaming parser for packed-integer log files, one byte per word.
// ---------------------------------------------------------------------------
// Feed the raw log file in order, one byte per input word; the block frames
// records on its own (14-byte header, optional 8-byte VLSN, payload) and
// emits one result word per decoded field plus a record-end word carrying a
// status. Throughput is one input byte per clock while the input is not
// stalled. A byte is captured in an input register and decoded in the next
// cycle by the parser core, whose state registers close the per-byte loop;
// its 0..3 result words land in an 8-entry result queue that drains one
// word per cycle while the result side is ready, so the first result word
// is offered only once it is written into the queue. The input stalls only
// when the queue might not hold the words of the byte in flight plus the next
// one, i.e. while the result side is backpressured or a run of multi-result
// bytes builds up. last_of_run marks the final word caused by a byte.
// ---------------------------------------------------------------------------
module packed_log_record_parser_unit
    import plrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    plrp_byte_if.sink  i_byte,
    plrp_rec_if.source o_rec
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   q_need;
    t_step_out         step;

    // room for the byte in flight and one more, worst case each
    assign q_need       = {1'b0, q_count} + (r_in_vld ? (QCNT_W+1)'(MAX_RES) : '0);
    assign i_byte.ready = (q_need <= (QCNT_W+1)'(QUEUE_DEPTH - MAX_RES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_byte.valid && i_byte.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    plrp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step_vld (r_in_vld),
        .i_byte     (r_in_byte),
        .o_step     (step)
    );

    plrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .o_count (q_count),
        .o_rec   (o_rec)
    );

endmodule

// File: design/plrp_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrp_core
// Parser state and per-byte decode; yields up to three results per byte.
// ---------------------------------------------------------------------------
module plrp_core
    import plrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step_vld,
    input  logic [7:0] i_byte,
    output t_step_out o_step
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_bidx, n_bidx;
    logic [7:0]  r_rtype, n_rtype;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_plen, n_plen;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_pbl, n_pbl;
    logic        r_neg, n_neg;
    logic [2:0]  r_pos, n_pos;
    logic [4:0]  r_fidx, n_fidx;
    logic [31:0] r_udl, n_udl;
    logic [7:0]  r_op_hi, n_op_hi;
    logic        r_abort, n_abort;

    // packed integer decode
    logic        pk_is32;
    t_pk_code    pk_code;
    logic [63:0] pk_val, pk_acc;
    logic [3:0]  pk_pbl;
    logic        pk_neg;
    logic [2:0]  pk_pos;
    logic [7:0]  pk_len8;
    logic [3:0]  pk_len;
    logic [31:0] pk_a32, pk_r32;

    logic [31:0] p, rem, dsize;
    logic [1:0]  hoff;
    logic [2:0]  foff;
    logic        do_start, do_end;
    logic [1:0]  cnt;
    t_result [MAX_RES-1:0] res;

    function automatic t_result mk(input logic [4:0] id, input logic [63:0] v,
                                   input logic [7:0] et, input logic [1:0] st);
        t_result r;
        r.field_id    = id;
        r.field_value = v;
        r.rec_type    = et;
        r.status      = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    always_comb begin
        pk_is32 = (r_phase == PH_COMMIT) ? (r_fidx == FID_CM_MASTER)
                                         : (r_fidx == FID_U_DSIZE);
        pk_code = PK_PEND;
        pk_val  = '0;
        pk_acc  = r_acc;
        pk_pbl  = r_pbl;
        pk_neg  = r_neg;
        pk_pos  = r_pos;
        pk_len8 = '0;
        pk_len  = '0;
        pk_a32  = '0;
        pk_r32  = '0;
        if (r_pbl == 4'd0) begin
            if (i_byte <= PACK_BIAS || i_byte >= PACK_NEG_LO) begin
                pk_code = PK_DONE;
                pk_val  = {{56{i_byte[7]}}, i_byte};
            end else begin
                pk_len8 = i_byte[7] ? (PACK_NEG_LO - i_byte) : (i_byte - PACK_BIAS);
                pk_len  = pk_len8[3:0];
                if (pk_len > (pk_is32 ? 4'd4 : 4'd8)) begin
                    pk_code = PK_BAD;
                end else begin
                    pk_pbl = pk_len;
                    pk_neg = i_byte[7];
                    pk_pos = '0;
                    pk_acc = '0;
                end
            end
        end else begin
            pk_acc = r_acc | (64'(i_byte) << {r_pos, 3'b000});
            pk_pos = r_pos + 3'd1;
            pk_pbl = r_pbl - 4'd1;
            if (pk_pbl == 4'd0) begin
                pk_code = PK_DONE;
                if (pk_is32) begin
                    pk_a32 = pk_acc[31:0];
                    pk_r32 = r_neg ? (32'd0 - pk_a32 - 32'd119) : (pk_a32 + 32'd119);
                    pk_val = {{32{pk_r32[31]}}, pk_r32};
                end else begin
                    pk_val = r_neg ? (64'd0 - pk_acc - 64'd119) : (pk_acc + 64'd119);
                end
            end
        end
    end

    always_comb begin
        n_phase = r_phase;  n_bidx  = r_bidx;  n_rtype = r_rtype;
        n_flags = r_flags;  n_plen  = r_plen;  n_acc   = r_acc;
        n_pbl   = r_pbl;    n_neg   = r_neg;   n_pos   = r_pos;
        n_fidx  = r_fidx;   n_udl   = r_udl;   n_op_hi = r_op_hi;
        n_abort = r_abort;
        p = r_bidx; rem = '0; dsize = '0; hoff = '0; foff = '0;
        do_start = 1'b0; do_end = 1'b0;
        cnt = '0;
        res = '0;

        if (r_phase == PH_HEADER) begin
            if (p == 32'd0) begin
                n_rtype = '0;
                n_acc   = '0;
            end
            if (p > 32'd13) begin
                n_bidx = '0;
            end else begin
                if (p < 32'd4)       hoff = p[1:0];
                else if (p < 32'd6)  hoff = 2'd0;
                else if (p < 32'd10) hoff = 2'(p[3:0] - 4'd6);
                else                 hoff = 2'(p[3:0] - 4'd10);
                n_acc  = n_acc | (64'(i_byte) << {hoff, 3'b000});
                n_bidx = p + 32'd1;
                priority case (p[3:0])
                    4'd3: begin
                        res[cnt] = mk(FID_CSUM, n_acc, n_rtype, ST_OK); cnt = cnt + 2'd1;
                        n_acc = '0;
                    end
                    4'd4: begin
                        n_rtype = i_byte;
                        res[cnt] = mk(FID_TYPE, 64'(i_byte), n_rtype, ST_OK);
                        cnt = cnt + 2'd1;
                        n_acc = '0;
                    end
                    4'd5: begin
                        n_flags = i_byte;
                        res[cnt] = mk(FID_FLAGS, 64'(i_byte), n_rtype, ST_OK);
                        cnt = cnt + 2'd1;
                        n_acc = '0;
                    end
                    4'd9: begin
                        res[cnt] = mk(FID_PREV, n_acc, n_rtype, ST_OK); cnt = cnt + 2'd1;
                        n_acc = '0;
                    end
                    4'd13: begin
                        n_plen = n_acc[31:0];
                        res[cnt] = mk(FID_SIZE, n_acc, n_rtype, ST_OK); cnt = cnt + 2'd1;
                        n_acc = '0;
                        if ((r_flags & FLAG_VLSN) != 8'd0) begin
                            n_phase = PH_VLSN;
                            n_bidx  = '0;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (r_phase == PH_VLSN) begin
            n_acc  = r_acc | (64'(i_byte) << {r_bidx[2:0], 3'b000});
            n_bidx = 32'(r_bidx[2:0]) + 32'd1;
            if (n_bidx == 32'd8) begin
                res[cnt] = mk(FID_VLSN, n_acc, n_rtype, ST_OK); cnt = cnt + 2'd1;
                do_start = 1'b1;
            end
        end else begin
            n_bidx = p + 32'd1;
            unique case (r_phase)
                PH_FILEHDR: begin
                    if (p > 32'd23) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        if (p < 32'd8)       foff = p[2:0];
                        else if (p < 32'd12) foff = 3'(p[4:0] - 5'd8);
                        else if (p < 32'd20) foff = 3'(p[4:0] - 5'd12);
                        else                 foff = 3'(p[4:0] - 5'd20);
                        n_acc = r_acc | (64'(i_byte) << {foff, 3'b000});
                        if (p == 32'd7 || p == 32'd11 || p == 32'd19 || p == 32'd23) begin
                            res[cnt] = mk(r_fidx, n_acc, n_rtype, ST_OK);
                            cnt = cnt + 2'd1;
                            n_acc  = '0;
                            n_fidx = r_fidx + 5'd1;
                            if (p == 32'd23) n_phase = PH_TRAIL;
                        end
                    end
                end
                PH_COMMIT: begin
                    if (pk_code == PK_BAD) begin
                        n_phase = PH_ERR_CODE;
                    end else begin
                        n_acc = pk_acc; n_pbl = pk_pbl; n_neg = pk_neg; n_pos = pk_pos;
                        if (pk_code == PK_DONE) begin
                            res[cnt] = mk(r_fidx, pk_val, n_rtype, ST_OK);
                            cnt = cnt + 2'd1;
                            if (r_fidx >= FID_CM_LAST) n_phase = PH_TRAIL;
                            else                       n_fidx  = r_fidx + 5'd1;
                        end
                    end
                end
                PH_USER: begin
                    if (r_fidx == FID_U_FLAG) begin
                        n_abort = i_byte[5];
                        res[cnt] = mk(FID_U_FLAG, 64'(i_byte), n_rtype, ST_OK);
                        cnt = cnt + 2'd1;
                        n_fidx = FID_U_FLAG2;
                    end else if (r_fidx == FID_U_FLAG2) begin
                        res[cnt] = mk(FID_U_FLAG2, 64'(i_byte), n_rtype, ST_OK);
                        cnt = cnt + 2'd1;
                        n_fidx = FID_U_DBID;
                    end else if (pk_code == PK_BAD) begin
                        n_phase = PH_ERR_CODE;
                    end else begin
                        n_acc = pk_acc; n_pbl = pk_pbl; n_neg = pk_neg; n_pos = pk_pos;
                        if (pk_code == PK_DONE) begin
                            res[cnt] = mk(r_fidx, pk_val, n_rtype, ST_OK);
                            cnt = cnt + 2'd1;
                            if (r_fidx == FID_U_DBID) begin
                                n_fidx = r_abort ? FID_U_ABORT : FID_U_TXN;
                            end else if (r_fidx < FID_U_DSIZE) begin
                                n_fidx = r_fidx + 5'd1;
                            end else begin
                                // data size: check the record leaves exactly an 8-byte key
                                rem   = r_plen - n_bidx;
                                dsize = pk_val[31:0];
                                if (pk_val[63] || dsize > rem) begin
                                    n_phase = PH_ERR_OVER;
                                end else if ((rem - dsize) != 32'd8) begin
                                    n_phase = PH_ERR_KEY;
                                end else begin
                                    n_udl = dsize;
                                    n_acc = '0;
                                    if (dsize < 32'd2) begin
                                        res[cnt] = mk(FID_U_OP, OP_NONE, n_rtype, ST_OK);
                                        cnt = cnt + 2'd1;
                                        n_fidx = FID_U_KEY;
                                    end else begin
                                        n_fidx = FID_U_OP;
                                        n_pbl  = 4'd2;
                                    end
                                    n_phase = (dsize == 32'd0) ? PH_KEY : PH_UDATA;
                                end
                            end
                        end
                    end
                end
                PH_UDATA: begin
                    if (r_fidx == FID_U_OP) begin
                        if (r_pbl == 4'd2) begin
                            n_op_hi = i_byte;
                            n_pbl   = 4'd1;
                        end else begin
                            res[cnt] = mk(FID_U_OP, 64'({r_op_hi, i_byte}), n_rtype, ST_OK);
                            cnt = cnt + 2'd1;
                            n_pbl  = '0;
                            n_fidx = FID_U_KEY;
                        end
                    end
                    if (r_udl != 32'd0) n_udl = r_udl - 32'd1;
                    if (n_udl == 32'd0) begin
                        n_phase = PH_KEY;
                        n_acc   = '0;
                    end
                end
                PH_KEY: begin
                    n_acc = {r_acc[55:0], i_byte};
                    if (n_bidx == r_plen) begin
                        res[cnt] = mk(FID_U_KEY, n_acc ^ KEY_FLIP, n_rtype, ST_OK);
                        cnt = cnt + 2'd1;
                        n_phase = PH_TRAIL;
                    end
                end
                default: ;
            endcase
            if (n_phase != PH_HEADER && n_bidx == r_plen) do_end = 1'b1;
        end

        if (do_start) begin
            n_bidx = '0;
            n_acc  = '0;
            n_pbl  = '0;
            if (n_rtype == TYPE_FILEHDR) begin
                n_phase = PH_FILEHDR; n_fidx = FID_FH_FIRST;
            end else if (n_rtype == TYPE_COMMIT) begin
                n_phase = PH_COMMIT;  n_fidx = FID_CM_FIRST;
            end else if (n_rtype == TYPE_USER) begin
                n_phase = PH_USER;    n_fidx = FID_U_FLAG;
            end else begin
                n_phase = PH_TRAIL;
            end
            if (n_plen == 32'd0) do_end = 1'b1;
        end

        if (do_end) begin
            res[cnt] = mk(FID_END, 64'd0, n_rtype, phase_status(n_phase));
            cnt = cnt + 2'd1;
            n_phase = PH_HEADER;
            n_bidx  = '0;
            n_fidx  = '0;
            n_pbl   = '0;
            n_acc   = '0;
        end

        if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;

        o_step.cnt = i_step_vld ? cnt : 2'd0;
        o_step.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_bidx  <= '0;  r_rtype <= '0;  r_flags <= '0;  r_plen  <= '0;
            r_acc   <= '0;  r_pbl   <= '0;  r_neg   <= 1'b0; r_pos  <= '0;
            r_fidx  <= '0;  r_udl   <= '0;  r_op_hi <= '0;  r_abort <= 1'b0;
        end else if (i_step_vld) begin
            r_phase <= n_phase;
            r_bidx  <= n_bidx;  r_rtype <= n_rtype; r_flags <= n_flags; r_plen <= n_plen;
            r_acc   <= n_acc;   r_pbl   <= n_pbl;   r_neg   <= n_neg;   r_pos  <= n_pos;
            r_fidx  <= n_fidx;  r_udl   <= n_udl;   r_op_hi <= n_op_hi; r_abort <= n_abort;
        end
    end

endmodule

// File: design/plrp_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plrp_fifo
// Result queue: takes up to three words per cycle, gives one per handshake.
// ---------------------------------------------------------------------------
module plrp_fifo
    import plrp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step_out         i_push,
    output logic [QCNT_W-1:0] o_count,
    plrp_rec_if.source        o_rec
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              pop;
    t_result           head;

    assign pop  = o_rec.valid && o_rec.ready;
    assign head = r_mem[r_rp];

    assign o_rec.valid       = (r_count != '0);
    assign o_rec.field_id    = head.field_id;
    assign o_rec.field_value = head.field_value;
    assign o_rec.rec_type    = head.rec_type;
    assign o_rec.status      = head.status;
    assign o_rec.last_of_run = head.last_of_run;
    assign o_count           = r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(i_push.cnt)) begin
                r_mem[r_wp + QPTR_W'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QPTR_W'(i_push.cnt);
            r_rp    <= r_rp + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + QCNT_W'(i_push.cnt)) <= (QCNT_W'(QUEUE_DEPTH) + QCNT_W'(pop)))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == r_count[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0 && !o_rec.valid))
        else $error("queue not empty after reset");

endmodule
